[hw/rtl/qsm_pkg.sv]
// ----------------------------------------------------------------------------
// qsm_pkg
// Shared widths and defaults for the quicksort-with-median block.
// ----------------------------------------------------------------------------
package qsm_pkg;

	localparam int DATA_W        = 32;
	localparam int OUT_W         = 2 * DATA_W;
	localparam int MAX_ITEMS_DEF = 64;

endpackage

[hw/rtl/quicksort_with_median.sv]
// ----------------------------------------------------------------------------
// quicksort_with_median
// Collects a set of signed values, sorts them in place, streams them back
// with the set median attached to each result.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one signed value per request on s_tdata, s_tlast marks the
//   final value of the set. Values beyond MAX_ITEMS are dropped and flagged.
//   Master stream: one sorted value per request, lowest first, with the median
//   in the upper half of m_tdata, the drop flag on m_tuser, and m_tlast on
//   the final value of the set.
//   Loading takes one value per cycle. The sort runs on one element store
//   with two read ports and one write port: each Lomuto step reads and
//   compares, with a write-back step when it swaps; each range adds pivot
//   fetch, final swap and stack traffic. The median follows the sort.
//   Each result is fetched only after the receiver has taken the one before.
//   s_tready is high only while loading; the block takes no request while
//   it sorts or streams results. A stalled receiver holds the current
//   result and stops the output sweep.
//   Reset empties the store and clears the drop flag and the output valid.
// ----------------------------------------------------------------------------
module quicksort_with_median
	import qsm_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // value
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // sorted_value, median
	output logic [0:0]        m_tuser,   // overflow
	output logic              m_tlast
);

	localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int ENT_W = 2 * IDX_W;

	localparam logic [3:0] ST_LOAD  = 4'd0;
	localparam logic [3:0] ST_POP   = 4'd1;
	localparam logic [3:0] ST_POPW  = 4'd2;
	localparam logic [3:0] ST_PIV   = 4'd3;
	localparam logic [3:0] ST_PRD   = 4'd4;
	localparam logic [3:0] ST_PCMP  = 4'd5;
	localparam logic [3:0] ST_PSW   = 4'd6;
	localparam logic [3:0] ST_FRD   = 4'd7;
	localparam logic [3:0] ST_FW1   = 4'd8;
	localparam logic [3:0] ST_FW2   = 4'd9;
	localparam logic [3:0] ST_PUSH1 = 4'd10;
	localparam logic [3:0] ST_PUSH2 = 4'd11;
	localparam logic [3:0] ST_MRD   = 4'd12;
	localparam logic [3:0] ST_MCALC = 4'd13;
	localparam logic [3:0] ST_OLD   = 4'd14;
	localparam logic [3:0] ST_OWAIT = 4'd15;

	logic [3:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic              dropped_q;
	logic [CNT_W-1:0]  sp_q;
	logic [IDX_W-1:0]  lo_q, hi_q, j_q, ip1_q, k_q;
	logic [DATA_W-1:0] pivot_q, tmp_q, median_q;

	logic              m_valid_q, m_last_q, m_ovf_q;
	logic [DATA_W-1:0] m_value_q;

	logic [DATA_W-1:0] mem [MAX_ITEMS];
	logic [DATA_W-1:0] rd0_q, rd1_q;
	logic              we;
	logic [IDX_W-1:0]  waddr, raddr0, raddr1;
	logic [DATA_W-1:0] wdata;

	logic [ENT_W-1:0]  stk [MAX_ITEMS];
	logic [ENT_W-1:0]  stk_rd_q;
	logic              stk_we;
	logic [IDX_W-1:0]  stk_waddr, stk_raddr;
	logic [ENT_W-1:0]  stk_wdata;

	logic              s_acc, m_acc, room, stk_room;
	logic [CNT_W-1:0]  n_next, half, last_idx, sp_dec;
	logic [IDX_W-1:0]  pop_lo, pop_hi, hi_m1;
	logic              lo_gt_p_m1, p_p1_lt_hi;
	logic [DATA_W:0]   sum, sum_adj;

	assign s_tready = (state_q == ST_LOAD);
	assign s_acc    = s_tvalid && s_tready;
	assign m_acc    = m_valid_q && m_tready;
	assign room     = (count_q < CNT_W'(MAX_ITEMS));
	assign stk_room = (sp_q < CNT_W'(MAX_ITEMS));
	assign n_next   = room ? CNT_W'(count_q + 1'b1) : count_q;
	assign half     = count_q >> 1;
	assign last_idx = CNT_W'(count_q - 1'b1);
	assign sp_dec   = CNT_W'(sp_q - 1'b1);
	assign pop_lo   = stk_rd_q[ENT_W-1:IDX_W];
	assign pop_hi   = stk_rd_q[IDX_W-1:0];
	assign hi_m1    = IDX_W'(hi_q - 1'b1);
	assign lo_gt_p_m1 = ({1'b0, ip1_q} > (IDX_W+1)'({1'b0, lo_q} + 1'b1));
	assign p_p1_lt_hi = ((IDX_W+1)'({1'b0, ip1_q} + 1'b1) < {1'b0, hi_q});
	assign sum      = {rd0_q[DATA_W-1], rd0_q} + {rd1_q[DATA_W-1], rd1_q};
	assign sum_adj  = sum + {{DATA_W{1'b0}}, sum[DATA_W]};

	assign stk_raddr = sp_dec[IDX_W-1:0];

	always_comb begin
		we        = 1'b0;
		waddr     = j_q;
		wdata     = rd0_q;
		raddr0    = j_q;
		raddr1    = ip1_q;
		stk_we    = 1'b0;
		stk_waddr = sp_q[IDX_W-1:0];
		stk_wdata = {lo_q, IDX_W'(ip1_q - 1'b1)};
		case (state_q)
			ST_LOAD: begin
				we        = s_acc && room;
				waddr     = count_q[IDX_W-1:0];
				wdata     = s_tdata;
				stk_we    = s_acc && s_tlast && (n_next > CNT_W'(1));
				stk_waddr = '0;
				stk_wdata = {{IDX_W{1'b0}}, last_idx[IDX_W-1:0] + IDX_W'(room)};
			end
			ST_POPW: begin
				raddr0 = pop_hi;
			end
			ST_PCMP: begin
				we    = ($signed(rd0_q) <= $signed(pivot_q));
				waddr = ip1_q;
				wdata = rd0_q;
			end
			ST_PSW: begin
				we    = 1'b1;
				waddr = j_q;
				wdata = tmp_q;
			end
			ST_FRD: begin
				raddr0 = ip1_q;
				raddr1 = hi_q;
			end
			ST_FW1: begin
				we    = 1'b1;
				waddr = ip1_q;
				wdata = rd1_q;
			end
			ST_FW2: begin
				we    = 1'b1;
				waddr = hi_q;
				wdata = tmp_q;
			end
			ST_PUSH1: begin
				stk_we    = lo_gt_p_m1 && stk_room;
				stk_wdata = {lo_q, IDX_W'(ip1_q - 1'b1)};
			end
			ST_PUSH2: begin
				stk_we    = p_p1_lt_hi && stk_room;
				stk_wdata = {IDX_W'(ip1_q + 1'b1), hi_q};
			end
			ST_MRD: begin
				raddr0 = IDX_W'(half - 1'b1);
				raddr1 = half[IDX_W-1:0];
			end
			ST_MCALC: begin
				raddr0 = '0;
			end
			ST_OWAIT: begin
				raddr0 = IDX_W'(k_q + 1'b1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd0_q <= mem[raddr0];
		rd1_q <= mem[raddr1];
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk[stk_waddr] <= stk_wdata;
		end
		stk_rd_q <= stk[stk_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			dropped_q <= 1'b0;
			sp_q      <= '0;
			m_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (s_acc) begin
						count_q <= n_next;
						if (!room) begin
							dropped_q <= 1'b1;
						end
						if (s_tlast) begin
							sp_q    <= (n_next > CNT_W'(1)) ? CNT_W'(1) : '0;
							state_q <= ST_POP;
						end
					end
				end
				ST_POP: begin
					if (sp_q == '0) begin
						state_q <= ST_MRD;
					end else begin
						sp_q    <= sp_dec;
						state_q <= ST_POPW;
					end
				end
				ST_POPW: begin
					state_q <= (pop_lo >= pop_hi) ? ST_POP : ST_PIV;
				end
				ST_PIV: begin
					state_q <= ST_PRD;
				end
				ST_PRD: begin
					state_q <= ST_PCMP;
				end
				ST_PCMP: begin
					if ($signed(rd0_q) <= $signed(pivot_q)) begin
						state_q <= ST_PSW;
					end else begin
						state_q <= (j_q == hi_m1) ? ST_FRD : ST_PRD;
					end
				end
				ST_PSW: begin
					state_q <= (j_q == hi_m1) ? ST_FRD : ST_PRD;
				end
				ST_FRD: begin
					state_q <= ST_FW1;
				end
				ST_FW1: begin
					state_q <= ST_FW2;
				end
				ST_FW2: begin
					state_q <= ST_PUSH1;
				end
				ST_PUSH1: begin
					if (lo_gt_p_m1 && stk_room) begin
						sp_q <= CNT_W'(sp_q + 1'b1);
					end
					state_q <= ST_PUSH2;
				end
				ST_PUSH2: begin
					if (p_p1_lt_hi && stk_room) begin
						sp_q <= CNT_W'(sp_q + 1'b1);
					end
					state_q <= ST_POP;
				end
				ST_MRD: begin
					state_q <= ST_MCALC;
				end
				ST_MCALC: begin
					state_q <= ST_OLD;
				end
				ST_OLD: begin
					m_valid_q <= 1'b1;
					state_q   <= ST_OWAIT;
				end
				ST_OWAIT: begin
					if (m_acc) begin
						m_valid_q <= 1'b0;
						if (m_last_q) begin
							count_q   <= '0;
							sp_q      <= '0;
							dropped_q <= 1'b0;
							state_q   <= ST_LOAD;
						end else begin
							state_q <= ST_OLD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_POPW: begin
				lo_q <= pop_lo;
				hi_q <= pop_hi;
			end
			ST_PIV: begin
				pivot_q <= rd0_q;
				j_q     <= lo_q;
				ip1_q   <= lo_q;
			end
			ST_PCMP: begin
				if ($signed(rd0_q) <= $signed(pivot_q)) begin
					tmp_q <= rd1_q;
				end else begin
					j_q <= IDX_W'(j_q + 1'b1);
				end
			end
			ST_PSW: begin
				j_q   <= IDX_W'(j_q + 1'b1);
				ip1_q <= IDX_W'(ip1_q + 1'b1);
			end
			ST_FW1: begin
				tmp_q <= rd0_q;
			end
			ST_MCALC: begin
				median_q <= count_q[0] ? rd1_q : sum_adj[DATA_W:1];
				k_q      <= '0;
			end
			ST_OLD: begin
				m_value_q <= rd0_q;
				m_last_q  <= ({1'b0, k_q} == last_idx);
				m_ovf_q   <= dropped_q;
			end
			ST_OWAIT: begin
				if (m_acc) begin
					k_q <= IDX_W'(k_q + 1'b1);
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = {median_q, m_value_q};
	assign m_tuser[0] = m_ovf_q;
	assign m_tlast    = m_last_q;

endmodule

[hw/rtl/qsm_checker.sv]
// ----------------------------------------------------------------------------
// qsm_checker
// Port-level checks for quicksort_with_median, bound to the top level.
// ----------------------------------------------------------------------------
module qsm_checker
	import qsm_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              s_tlast,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [OUT_W-1:0]  m_tdata,
	input logic              m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	a_no_load_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("request taken while results pending");

	a_end_of_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid)
		else $error("result after end of run");

	a_sort_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("load continued after last request");

	a_keep_loading: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tlast |=> s_tready)
		else $error("load stopped before last request");

endmodule

bind quicksort_with_median qsm_checker u_qsm_checker (.*);
